// ----- hdl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cell engine package
// Command codes, controller states and the words passed between the
// controller, the cell store and the output stage.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Command codes carried in the input word's tuser.
    localparam logic [2:0] ACT_PRINT   = 3'd0;
    localparam logic [2:0] ACT_NEWLINE = 3'd1;
    localparam logic [2:0] ACT_CLEAR   = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_DELETE  = 3'd4;

    // A blank cell is character 0 with attribute 7.
    localparam logic [15:0] BLANK_CELL = 16'h0700;

    // Width of the hardware cursor location result field.
    localparam int HW_W = 12;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic [2:0]        action;
        logic signed [11:0] offset;
        logic [3:0]        back_colour;
        logic [3:0]        fore_colour;
        logic [4:0]        row;
        logic [6:0]        column;
        logic [7:0]        symbol;
    } cmd_t;

    typedef struct packed {
        logic              error;
        logic [HW_W-1:0]   hw_cursor_location;
        logic [4:0]        cursor_row;
        logic [6:0]        cursor_col;
        logic [7:0]        read_symbol;
    } result_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

// ----- hdl/tcce_cell_ram.sv -----
// ----------------------------------------------------------------------------
// Character cell store
// Single-port synchronous memory of screen cells with a registered read.
// ----------------------------------------------------------------------------
module tcce_cell_ram
    import tcce_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
)
(
    input  logic              clk,
    input  ram_ctl_t          ctl,
    input  logic [ADDR_W-1:0] addr,
    input  logic [15:0]       wdata,
    output logic [15:0]       rdata
);

    logic [15:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- hdl/tcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// Console controller
// Holds the cursor, decodes each command, drives the cell store and sweeps
// the store with blank cells after reset and on a screen clear.
// ----------------------------------------------------------------------------
module tcce_ctrl
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cmd_t                                  in_cmd,
    input  logic                                  res_ready,
    output logic                                  res_valid,
    output result_t                               res,
    output ram_ctl_t                              ram_ctl,
    output logic [$clog2(COLUMNS*ROWS)-1:0]       ram_addr,
    output logic [15:0]                           ram_wdata,
    input  logic [15:0]                           ram_rdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int LIN_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int LINE_W     = $clog2(ROWS + 1);
    localparam int SUM_W      = ((LIN_W > 12) ? LIN_W : 12) + 2;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [LIN_W-1:0]    lin_reg, lin_next;
    logic [HW_W-1:0]     hw_reg, hw_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;

    logic [LIN_W-1:0]    p_addr;
    logic                p_ok;
    logic signed [SUM_W-1:0] off_sum;
    logic                off_ok;
    logic                nl_wrap;
    logic                clr_last;
    logic                err;
    logic [7:0]          rsym;

    // Cell addressed by a print, and its range check.
    assign p_addr = LIN_W'(LIN_W'(cmd_reg.row) * LIN_W'(COLUMNS)) + LIN_W'(cmd_reg.column);
    assign p_ok   = (int'(cmd_reg.column) < COLUMNS) && (int'(cmd_reg.row) < ROWS);

    // Cell at the cursor plus the signed offset, and its range check.
    assign off_sum = $signed(SUM_W'(lin_reg)) + SUM_W'($signed(cmd_reg.offset));
    assign off_ok  = !off_sum[SUM_W-1] && (off_sum < $signed(SUM_W'(CELL_COUNT)));

    assign nl_wrap  = int'(line_reg) >= (ROWS - 1);
    assign clr_last = clr_cnt_reg == ADDR_W'(CELL_COUNT - 1);

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            line_reg    <= '0;
            col_reg     <= '0;
            lin_reg     <= '0;
            hw_reg      <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            lin_reg     <= lin_next;
            hw_reg      <= hw_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Command word captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_cmd;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((cmd_reg.action == ACT_READ) && off_ok)
                begin
                    state_next = ST_FETCH;
                end
                else if (res_ready)
                begin
                    if ((cmd_reg.action == ACT_CLEAR) ||
                        ((cmd_reg.action == ACT_NEWLINE) && nl_wrap))
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs, store access and cursor updates.
    always_comb
    begin
        in_ready     = 1'b0;
        ram_ctl      = '0;
        ram_addr     = ADDR_W'(p_addr);
        ram_wdata    = BLANK_CELL;
        res_valid    = 1'b0;
        line_next    = line_reg;
        col_next     = col_reg;
        lin_next     = lin_reg;
        hw_next      = hw_reg;
        clr_cnt_next = clr_cnt_reg;
        err          = 1'b0;
        rsym         = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_ctl.wr_en = 1'b1;
                ram_addr      = clr_cnt_reg;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                if ((cmd_reg.action == ACT_READ) && off_ok)
                begin
                    ram_ctl.rd_en = 1'b1;
                    ram_addr      = ADDR_W'(off_sum);
                end
                else if (res_ready)
                begin
                    res_valid = 1'b1;
                    case (cmd_reg.action)
                        ACT_PRINT:
                        begin
                            err = !p_ok;
                            if (p_ok)
                            begin
                                ram_ctl.wr_en = 1'b1;
                                ram_wdata     = {cmd_reg.back_colour, cmd_reg.fore_colour,
                                                 cmd_reg.symbol};
                                lin_next      = p_addr + LIN_W'(1);
                                if (int'(cmd_reg.column) == (COLUMNS - 1))
                                begin
                                    line_next = LINE_W'(int'(cmd_reg.row) + 1);
                                    col_next  = '0;
                                end
                                else
                                begin
                                    line_next = LINE_W'(cmd_reg.row);
                                    col_next  = COL_W'(int'(cmd_reg.column) + 1);
                                end
                            end
                        end
                        ACT_NEWLINE:
                        begin
                            if (nl_wrap)
                            begin
                                line_next    = '0;
                                col_next     = '0;
                                lin_next     = '0;
                                hw_next      = '0;
                                clr_cnt_next = '0;
                            end
                            else
                            begin
                                line_next = line_reg + 1'b1;
                                col_next  = '0;
                                lin_next  = lin_reg - LIN_W'(col_reg) + LIN_W'(COLUMNS);
                                hw_next   = HW_W'(lin_reg - LIN_W'(col_reg) + LIN_W'(COLUMNS));
                            end
                        end
                        ACT_CLEAR:
                        begin
                            line_next    = '0;
                            col_next     = '0;
                            lin_next     = '0;
                            hw_next      = '0;
                            clr_cnt_next = '0;
                        end
                        ACT_READ:
                        begin
                            // Only an off-screen read lands here.
                            err = 1'b1;
                        end
                        ACT_DELETE:
                        begin
                            err = !off_ok;
                            if (off_ok)
                            begin
                                ram_ctl.wr_en = 1'b1;
                                ram_addr      = ADDR_W'(off_sum);
                                if (col_reg != '0)
                                begin
                                    col_next = col_reg - 1'b1;
                                    lin_next = lin_reg - 1'b1;
                                    hw_next  = HW_W'(lin_reg - 1'b1);
                                end
                                else if (line_reg != '0)
                                begin
                                    line_next = line_reg - 1'b1;
                                    col_next  = COL_W'(COLUMNS - 1);
                                    lin_next  = lin_reg - 1'b1;
                                    hw_next   = HW_W'(lin_reg - 1'b1);
                                end
                            end
                        end
                        default:
                        begin
                            err = 1'b0;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (res_ready)
                begin
                    res_valid = 1'b1;
                    rsym      = ram_rdata[7:0];
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase

        res.read_symbol        = rsym;
        res.cursor_col         = 7'(col_next);
        res.cursor_row         = 5'(line_next);
        res.hw_cursor_location = hw_next;
        res.error              = err;
    end

endmodule

// ----- hdl/text_console_cell_engine.sv -----
// ----------------------------------------------------------------------------
// Text console cell engine
// Character cell store with a text cursor, driven by a stream of commands.
// ----------------------------------------------------------------------------
// Each command word produces exactly one result word. A command is accepted
// in the idle state and carried out in the execute state, in which a print or
// delete writes the cell store; a read in range also passes through a fetch state
// for the registered store read. The single-port store is swept with blank cells
// after reset and after every clear, including a new line past the last row,
// one cell per cycle over all COLUMNS*ROWS cells (2000 at the default size),
// during which no command is accepted. The result of a clear is issued before
// its sweep starts. A finished result waits in an output register, so the
// command side is not held while the result is being taken.
// ----------------------------------------------------------------------------
module text_console_cell_engine
    import tcce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // symbol[7:0], column[14:8], row[19:15], fore_colour[23:20],
    // back_colour[27:24], offset[39:28]
    input  logic [39:0] s_axis_tdata,
    // action[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_symbol[7:0], cursor_col[14:8], cursor_row[19:15],
    // hw_cursor_location[31:20]
    output logic [31:0] m_axis_tdata,
    // error[0]
    output logic        m_axis_tuser
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    cmd_t              in_cmd;
    result_t           res;
    logic              res_valid;
    logic              res_ready;
    ram_ctl_t          ram_ctl;
    logic [ADDR_W-1:0] ram_addr;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_rdata;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    // Unpack the command word.
    always_comb
    begin
        in_cmd.action      = s_axis_tuser;
        in_cmd.symbol      = s_axis_tdata[7:0];
        in_cmd.column      = s_axis_tdata[14:8];
        in_cmd.row         = s_axis_tdata[19:15];
        in_cmd.fore_colour = s_axis_tdata[23:20];
        in_cmd.back_colour = s_axis_tdata[27:24];
        in_cmd.offset      = s_axis_tdata[39:28];
    end

    tcce_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (in_cmd),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .ram_ctl   (ram_ctl),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    tcce_cell_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Output register: a new result may enter when the slot is empty or
    // is being taken in the same cycle.
    assign res_ready      = !out_valid_reg || m_axis_tready;
    assign out_valid_next = res_valid || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.hw_cursor_location, out_res_reg.cursor_row,
                            out_res_reg.cursor_col, out_res_reg.read_symbol};
    assign m_axis_tuser  = out_res_reg.error;

    // The store is never written while the block waits for a command.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !ram_ctl.wr_en)
        else $error("cell store written while waiting for a command");

    // Only one command is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command accepted while another is in flight");

    // A failed command never returns a character.
    a_err_no_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("error result carries a character");

    // A result is produced only when the output slot can take it.
    a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid_reg || m_axis_tready))
        else $error("result produced while the output register is full");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Text console cell engine testbench
// Drives print, new line, clear, read and delete command words into the
// console and checks every result word against a mirror of the character
// store and cursor kept in the bench. Short directed tests cover the screen
// edges, cursor wrapping, off-screen addresses and unused command codes. A
// long random test then types text, reads it back and deletes it, mixed with
// noise, with both stream sides idling at random; a result hold-off precedes it.
// ----------------------------------------------------------------------------
module tb
    import tcce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int RANDOM_ITEMS = 1600;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_CYCLES  = 150;

    // Command codes that the console must ignore.
    localparam logic [2:0] ACT_SPARE5 = 3'd5;
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    // Extremes of the signed cell offset.
    localparam int OFFSET_MAX = 2047;
    localparam int OFFSET_MIN = -2048;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    // Mirror of the console: cell store, text cursor and hardware cursor.
    logic [15:0] screen_mirror [0:CELLS-1];
    int          mirror_col;
    int          mirror_row;
    int          mirror_hw;

    // Results still owed by the console, oldest first.
    result_t     pending_results [$];

    int          fault_count    = 0;
    int          action_count [0:7];
    int          off_screen_count = 0;
    int          symbol_hits    = 0;
    bit          steady         = 1'b0;
    int          hold_request   = 0;
    int          hold_left      = 0;

    text_console_cell_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Blank every cell and send the cursor home.
    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = BLANK_CELL;
        mirror_col = 0;
        mirror_row = 0;
        mirror_hw  = 0;
    endfunction

    // Apply one command to the mirror and return the result it must produce.
    function automatic result_t next_console_result(cmd_t c);
        result_t r;
        int      addr;
        r    = '0;
        addr = mirror_row * COLUMNS + mirror_col + int'($signed(c.offset));
        case (c.action)
            ACT_PRINT:
            begin
                if (c.column >= COLUMNS || c.row >= ROWS)
                    r.error = 1'b1;
                else
                begin
                    screen_mirror[c.row * COLUMNS + c.column] =
                        {c.back_colour, c.fore_colour, c.symbol};
                    if (c.column + 1 > COLUMNS - 1)
                    begin
                        mirror_row = c.row + 1;
                        mirror_col = 0;
                    end
                    else
                    begin
                        mirror_col = c.column + 1;
                        mirror_row = c.row;
                    end
                end
            end
            ACT_NEWLINE:
            begin
                // Past the last row a new line wipes the screen.
                if (mirror_row >= ROWS - 1)
                    blank_screen();
                else
                begin
                    mirror_row = mirror_row + 1;
                    mirror_col = 0;
                    mirror_hw  = mirror_row * COLUMNS;
                end
            end
            ACT_CLEAR:
                blank_screen();
            ACT_READ:
            begin
                if (addr < 0 || addr >= CELLS)
                    r.error = 1'b1;
                else
                    r.read_symbol = screen_mirror[addr][7:0];
            end
            ACT_DELETE:
            begin
                if (addr < 0 || addr >= CELLS)
                    r.error = 1'b1;
                else
                begin
                    screen_mirror[addr] = BLANK_CELL;
                    // Step back, wrapping to the end of the line above; at home nothing moves.
                    if (mirror_col == 0)
                    begin
                        if (mirror_row > 0)
                        begin
                            mirror_row = mirror_row - 1;
                            mirror_col = COLUMNS - 1;
                            mirror_hw  = mirror_row * COLUMNS + mirror_col;
                        end
                    end
                    else
                    begin
                        mirror_col = mirror_col - 1;
                        mirror_hw  = mirror_row * COLUMNS + mirror_col;
                    end
                end
            end
            default:
                ;
        endcase
        r.cursor_col         = 7'(mirror_col);
        r.cursor_row         = 5'(mirror_row);
        r.hw_cursor_location = HW_W'(mirror_hw);
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] act, int sym, int col, int row,
                                      int fore, int back, int off);
        cmd_t c;
        c.action      = act;
        c.symbol      = 8'(sym);
        c.column      = 7'(col);
        c.row         = 5'(row);
        c.fore_colour = 4'(fore);
        c.back_colour = 4'(back);
        c.offset      = 12'(off);
        return c;
    endfunction

    // Offset from the mirrored cursor to a given cell.
    function automatic int offset_to(int col, int row);
        return row * COLUMNS + col - (mirror_row * COLUMNS + mirror_col);
    endfunction

    function automatic cmd_t random_cmd();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[42:0];
    endfunction

    // Print at the cursor as a typist would, now and then at a random cell; past the last row, a new line.
    function automatic cmd_t typing_cmd();
        cmd_t c;
        c = random_cmd();
        c.action = ACT_PRINT;
        if (mirror_row >= ROWS)
            c.action = ACT_NEWLINE;
        else if ($urandom_range(0, 7) == 0)
        begin
            c.column = 7'($urandom_range(0, COLUMNS - 1));
            c.row    = 5'($urandom_range(0, ROWS - 1));
        end
        else
        begin
            c.column = 7'(mirror_col);
            c.row    = 5'(mirror_row);
        end
        return c;
    endfunction

    // Mostly typing, with new lines, rare clears, and reads and deletes near the cursor; the rest is noise.
    function automatic cmd_t pick_command();
        cmd_t c;
        int   dice;
        dice = $urandom_range(0, 99);
        c    = random_cmd();
        if (dice < 45)
            c = typing_cmd();
        else if (dice < 55)
            c.action = ACT_NEWLINE;
        else if (dice < 56)
            c.action = ACT_CLEAR;
        else if (dice < 72)
        begin
            c.action = ACT_READ;
            c.offset = 12'($urandom_range(0, 90) - 80);
        end
        else if (dice < 82)
        begin
            c.action = ACT_DELETE;
            c.offset = 12'($urandom_range(0, 7) - 5);
        end
        return c;
    endfunction

    // Offer one command word and wait for it to be taken. Called and left at a
    // falling edge with tvalid still high.
    task automatic send_cmd(input cmd_t c);
        result_t r;
        if (!steady && $urandom_range(0, 99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c[39:0];
        s_axis_tuser  <= c.action;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = next_console_result(c);
        pending_results.push_back(r);
        action_count[c.action]++;
        if (r.error)
            off_screen_count++;
        if (c.action == ACT_READ && r.read_symbol != 8'd0)
            symbol_hits++;
        @(negedge clk);
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
    endtask

    // Corners of the screen, wrapping and off-screen targets.
    task automatic test_print_edges();
        send_cmd(make_cmd(ACT_PRINT, 8'h00, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_PRINT, 8'hFF, COLUMNS - 1, ROWS - 1, 15, 15, 0));
        send_cmd(make_cmd(ACT_PRINT, 8'hA5, COLUMNS - 2, 3, 4, 1, 0));
        send_cmd(make_cmd(ACT_PRINT, 8'h41, COLUMNS, 0, 2, 3, 0));
        send_cmd(make_cmd(ACT_PRINT, 8'h42, 127, 31, 2, 3, 0));
        send_cmd(make_cmd(ACT_PRINT, 8'h43, 5, ROWS, 2, 3, 0));
        send_cmd(make_cmd(ACT_PRINT, 8'h5A, 0, ROWS - 1, 9, 6, 0));
    endtask

    // Reads and deletes around the cursor, wrapping back across a line start.
    task automatic test_read_delete();
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, offset_to(COLUMNS - 2, 3)));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, OFFSET_MAX));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, OFFSET_MIN));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, offset_to(0, 0)));
        send_cmd(make_cmd(ACT_DELETE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_DELETE, 0, 0, 0, 0, 0, offset_to(COLUMNS - 2, 3)));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, offset_to(COLUMNS - 2, 3)));
        send_cmd(make_cmd(ACT_DELETE, 0, 0, 0, 0, 0, OFFSET_MIN));
    endtask

    // New line on the last row, clear, and a delete with the cursor at home.
    task automatic test_newline_clear();
        send_cmd(make_cmd(ACT_NEWLINE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_NEWLINE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_DELETE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_NEWLINE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_PRINT, 8'h33, COLUMNS - 1, ROWS - 1, 7, 0, 0));
        send_cmd(make_cmd(ACT_NEWLINE, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(ACT_READ, 0, 0, 0, 0, 0, offset_to(COLUMNS - 1, ROWS - 1)));
        send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    endtask

    // Unused codes carry random fields and must leave everything alone.
    task automatic test_unused_actions();
        cmd_t c;
        c = random_cmd();
        c.action = ACT_SPARE5;
        send_cmd(c);
        c = random_cmd();
        c.action = ACT_SPARE6;
        send_cmd(c);
        c = random_cmd();
        c.action = ACT_SPARE7;
        send_cmd(c);
    endtask

    // The result side stops for a long stretch while typing continues.
    task automatic test_backpressure();
        idle_input();
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        @(negedge clk);
        for (int k = 0; k < 24; k++)
            send_cmd(typing_cmd());
    endtask

    // Random traffic with a stretch in the middle where neither side idles.
    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 600 && n < 900);
            send_cmd(pick_command());
        end
        steady = 1'b0;
    endtask

    // Result side: random idling, or a hold-off counted down cycle by cycle.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_request > 0)
        begin
            hold_left    = hold_request - 1;
            hold_request = 0;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);
    end

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = {m_axis_tuser, m_axis_tdata};
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("%t: result word with none expected: %s%h col %0d row %0d hw %0d err %b",
                             $realtime, "sym ", seen.read_symbol, seen.cursor_col,
                             seen.cursor_row, seen.hw_cursor_location, seen.error);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $write("%t: mismatch: expected sym %h col %0d row %0d hw %0d err %b, ",
                               $realtime, want.read_symbol, want.cursor_col, want.cursor_row,
                               want.hw_cursor_location, want.error);
                        $display("got sym %h col %0d row %0d hw %0d err %b",
                                 seen.read_symbol, seen.cursor_col, seen.cursor_row,
                                 seen.hw_cursor_location, seen.error);
                    end
                end
            end
        end
    end

    // Watchdog for a console that stops answering.
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        for (int a = 0; a < 8; a++)
            action_count[a] = 0;
        blank_screen();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_print_edges();
        test_read_delete();
        test_newline_clear();
        test_unused_actions();
        test_backpressure();
        test_random_traffic();

        // Drain, then watch a little longer for stray result words.
        idle_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            fault_count++;

        $write("Covered %0d prints, %0d new lines, %0d clears, ",
               action_count[ACT_PRINT], action_count[ACT_NEWLINE], action_count[ACT_CLEAR]);
        $display("%0d reads, %0d deletes, %0d unused codes.",
                 action_count[ACT_READ], action_count[ACT_DELETE],
                 action_count[ACT_SPARE5] + action_count[ACT_SPARE6] + action_count[ACT_SPARE7]);
        $display("%0d commands addressed off-screen cells; %0d reads returned a written symbol.",
                 off_screen_count, symbol_hits);
        if (fault_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
